@@ design/eafr_pkg.sv @@
// Package for the encoder angle frame receiver.
// Holds the item structs, frame constants and the CRC-8 byte update.
// No dependencies.
package eafr_pkg;

  localparam int unsigned AngleW    = 21;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned PosW      = 3;
  localparam logic [7:0]  CrcPoly   = 8'h07;
  localparam logic [7:0]  CrcInit   = 8'h00;
  localparam logic [PosW-1:0] PosIdle     = 3'd7;
  localparam logic [PosW-1:0] PosAngleHi  = 3'd2;
  localparam logic [PosW-1:0] PosAngleMid = 3'd3;
  localparam logic [PosW-1:0] PosAngleLo  = 3'd4;
  localparam logic [PosW-1:0] PosCrc      = 3'd5;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [AngleW-1:0]  angle;
    logic [StatusW-1:0] status;
    logic               crc_ok;
    logic [7:0]         received_crc;
  } out_item_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ design/eafr_frame_ctl.sv @@
// Frame tracker: byte position, angle bytes, running CRC and last status.
// Produces at most one result per item. Depends on eafr_pkg.
module eafr_frame_ctl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                crc_en_i,
  input  eafr_pkg::in_item_t  item_i,
  output logic                res_valid_o,
  output eafr_pkg::out_item_t res_o
);
  import eafr_pkg::*;

  logic [PosW-1:0]    pos_q, pos_d, pos_cur, last_idx;
  logic [23:0]        bytes_q, bytes_d;
  logic [7:0]         crc_q, crc_d;
  logic [StatusW-1:0] status_q, status_d;
  logic               ok;
  logic [7:0]         rcrc;

  always_comb begin
    pos_cur     = item_i.frame_start ? '0 : pos_q;
    last_idx    = crc_en_i ? PosCrc : PosAngleLo;
    pos_d       = pos_cur + 3'd1;
    bytes_d     = bytes_q;
    crc_d       = crc_q;
    status_d    = status_q;
    res_valid_o = 1'b0;
    ok          = 1'b1;
    rcrc        = 8'h00;

    if (pos_cur > last_idx) begin
      pos_d = PosIdle;
    end else if (pos_cur < PosAngleHi) begin
      pos_d = pos_cur + 3'd1;
    end else if (pos_cur <= PosAngleLo) begin
      if (pos_cur == PosAngleHi) begin
        bytes_d = {item_i.rx_byte, 16'h0000};
        crc_d   = crc8_byte(CrcInit, item_i.rx_byte);
      end else begin
        if (pos_cur == PosAngleMid) begin
          bytes_d = bytes_q | {8'h00, item_i.rx_byte, 8'h00};
        end else begin
          bytes_d = bytes_q | {16'h0000, item_i.rx_byte};
        end
        crc_d = crc8_byte(crc_q, item_i.rx_byte);
      end
      res_valid_o = (pos_cur == last_idx);
    end else begin
      rcrc        = item_i.rx_byte;
      ok          = (crc_q == item_i.rx_byte);
      res_valid_o = 1'b1;
    end

    if (res_valid_o) begin
      pos_d = PosIdle;
      if (ok) begin
        status_d = bytes_d[StatusW-1:0];
      end
    end

    res_o.angle        = ok ? bytes_d[23:3] : '0;
    res_o.status       = status_d;
    res_o.crc_ok       = ok;
    res_o.received_crc = rcrc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      bytes_q  <= '0;
      crc_q    <= CrcInit;
      status_q <= '0;
    end else if (step_i) begin
      pos_q    <= pos_d;
      bytes_q  <= bytes_d;
      crc_q    <= crc_d;
      status_q <= status_d;
    end
  end

endmodule

@@ design/encoder_angle_frame_receiver_top.sv @@
// Encoder angle frame receiver: one SPI burst byte per item, at most one result per frame.
// Latency: the result is valid the cycle after the last byte of a frame is taken.
// Throughput: one byte per cycle unless a held result waits on out_ready_i; the output register frees as it is drained.
// Reset clears position, angle, CRC, status and the crc_enable register.
// Depends on eafr_pkg and eafr_frame_ctl.
module encoder_angle_frame_receiver_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  eafr_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output eafr_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i
);
  import eafr_pkg::*;

  logic      crc_en_q;
  logic      out_valid_q;
  out_item_t out_q;
  logic      step;
  logic      res_valid;
  out_item_t res;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  eafr_frame_ctl u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .crc_en_i    (crc_en_q),
    .item_i      (in_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      crc_en_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_fail_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.crc_ok |-> out_data_o.angle == '0)
    else $error("failed CRC result carries nonzero angle");

  a_no_crc_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !crc_en_q |-> out_data_o.crc_ok && out_data_o.received_crc == 8'h00)
    else $error("result without CRC check reports a CRC");

  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result appeared without an accepted item");

  a_status_holds_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && res_valid && !res.crc_ok |-> res.status == u_frame.status_q)
    else $error("status changed on CRC mismatch");

endmodule

@@ verif/encoder_angle_frame_receiver_top_tb.sv @@
// Self-checking bench for encoder_angle_frame_receiver_top: directed frames, then random bursts.
// Results are predicted per byte and compared field by field in arrival order.
// Depends on eafr_pkg and the receiver RTL.
module encoder_angle_frame_receiver_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eafr_pkg::*;

  localparam int unsigned Phases     = 10;
  localparam int unsigned PhaseItems = 65;
  localparam int unsigned Settle     = 4;
  localparam int unsigned Drain      = 10;
  localparam int unsigned Limit      = 400000;

  typedef struct packed {
    logic      is_cfg;
    logic      cfg_val;
    logic      chk;
    in_item_t  item;
    out_item_t want;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_we_i    = 1'b0;
  logic      cfg_wdata_i = 1'b0;

  out_item_t   angles_due[$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  logic        gap_on     = 1'b1;
  logic        stall_on   = 1'b1;

  logic [2:0]  frm_pos       = '0;
  logic [23:0] frm_bytes     = '0;
  logic [7:0]  frm_crc       = CrcInit;
  logic [2:0]  frm_status    = '0;
  logic        crc_en_shadow = 1'b0;

  always #1 clk_i = ~clk_i;

  encoder_angle_frame_receiver_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ d[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return c;
  endfunction

  function automatic logic angle_frame_step(input in_item_t it, output out_item_t res);
    logic [2:0] last_pos;
    logic       ok;
    logic [7:0] rcrc;
    last_pos = crc_en_shadow ? PosCrc : PosAngleLo;
    res      = '0;
    if (it.frame_start) frm_pos = '0;
    if (frm_pos > last_pos) begin
      frm_pos = PosIdle;
      return 1'b0;
    end
    if (frm_pos < PosAngleHi) begin
      frm_pos = frm_pos + 3'd1;
      return 1'b0;
    end
    if (frm_pos <= PosAngleLo) begin
      frm_crc = crc_next((frm_pos == PosAngleHi) ? CrcInit : frm_crc, it.rx_byte);
      case (frm_pos)
        PosAngleHi:  frm_bytes = {it.rx_byte, 16'h0000};
        PosAngleMid: frm_bytes[15:8] = it.rx_byte;
        default:     frm_bytes[7:0] = it.rx_byte;
      endcase
      if (frm_pos < last_pos) begin
        frm_pos = frm_pos + 3'd1;
        return 1'b0;
      end
      rcrc = '0;
      ok   = 1'b1;
    end else begin
      rcrc = it.rx_byte;
      ok   = (frm_crc == it.rx_byte);
    end
    frm_pos = PosIdle;
    if (ok) frm_status = frm_bytes[2:0];
    res.angle        = ok ? frm_bytes[23:3] : '0;
    res.status       = frm_status;
    res.crc_ok       = ok;
    res.received_crc = rcrc;
    return 1'b1;
  endfunction

  function automatic dir_row_t item_row(input logic [7:0] d, input logic s);
    dir_row_t r;
    r      = '0;
    r.item = '{rx_byte: d, frame_start: s};
    return r;
  endfunction

  function automatic dir_row_t result_row(input logic [7:0] d, input logic s,
                                          input logic [AngleW-1:0] a, input logic [2:0] st,
                                          input logic ok, input logic [7:0] rc);
    dir_row_t r;
    r      = item_row(d, s);
    r.chk  = 1'b1;
    r.want = '{angle: a, status: st, crc_ok: ok, received_crc: rc};
    return r;
  endfunction

  function automatic dir_row_t crc_en_row(input logic v);
    dir_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.cfg_val = v;
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic s, input logic chk,
                           input out_item_t typed);
    int unsigned gap;
    in_item_t    it;
    out_item_t   res;
    logic        got;
    gap = gap_on ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it = '{rx_byte: d, frame_start: s};
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    got = angle_frame_step(it, res);
    if (got || chk) angles_due.push_back(chk ? typed : res);
  endtask

  task automatic write_crc_enable(input logic v);
    in_valid_i <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    crc_en_shadow  = v;
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %h, got %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (angles_due.size() == 0) begin
        $display("%0t ns: result with nothing due, expected none, got %h", $time, out_data_o);
        mismatches++;
      end else begin
        want = angles_due.pop_front();
        check_field("angle", 32'(want.angle), 32'(out_data_o.angle));
        check_field("status", 32'(want.status), 32'(out_data_o.status));
        check_field("crc_ok", 32'(want.crc_ok), 32'(out_data_o.crc_ok));
        check_field("received_crc", 32'(want.received_crc), 32'(out_data_o.received_crc));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= Limit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = stall_on ? $urandom_range(0, 9) : 0;
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      if ($urandom_range(0, 39) == 0) stall_on = !stall_on;
    end
  end

  initial begin
    dir_row_t    dir_rows[$];
    int unsigned sent;
    int unsigned n;
    logic [7:0]  a0, a1, a2;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_rows = '{
      item_row(8'h00, 1'b0), item_row(8'h00, 1'b0), item_row(8'hFF, 1'b0),
      item_row(8'hFF, 1'b0), result_row(8'hFF, 1'b0, 21'h1FFFFF, 3'd7, 1'b1, 8'h00),
      crc_en_row(1'b1),
      item_row(8'hA5, 1'b1), item_row(8'h5A, 1'b0), item_row(8'hFF, 1'b0),
      item_row(8'hFF, 1'b0), item_row(8'hFF, 1'b0),
      result_row(8'h0F, 1'b0, 21'h1FFFFF, 3'd7, 1'b1, 8'h0F),
      item_row(8'h00, 1'b1), item_row(8'h00, 1'b1), item_row(8'h00, 1'b0),
      item_row(8'h00, 1'b0), item_row(8'h00, 1'b0), item_row(8'h00, 1'b0),
      result_row(8'hFF, 1'b0, 21'h000000, 3'd7, 1'b0, 8'hFF),
      item_row(8'h81, 1'b1), item_row(8'h18, 1'b0), item_row(8'hAA, 1'b0),
      item_row(8'h55, 1'b0), item_row(8'h99, 1'b0),
      crc_en_row(1'b0),
      item_row(8'hE7, 1'b0),
      item_row(8'hC3, 1'b1), item_row(8'h3C, 1'b0), item_row(8'h00, 1'b0),
      item_row(8'h00, 1'b0),
      crc_en_row(1'b1),
      item_row(8'h00, 1'b0),
      result_row(8'h00, 1'b0, 21'h000000, 3'd0, 1'b1, 8'h00)
    };

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_crc_enable(dir_rows[i].cfg_val);
      end else begin
        send_byte(dir_rows[i].item.rx_byte, dir_rows[i].item.frame_start,
                  dir_rows[i].chk, dir_rows[i].want);
      end
    end

    for (int unsigned phase = 0; phase < Phases; phase++) begin
      write_crc_enable(phase[0]);
      gap_on = ($urandom_range(0, 2) != 0);
      sent   = 0;
      while (sent < PhaseItems) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: begin
            a0 = pick_byte();
            a1 = pick_byte();
            a2 = pick_byte();
            send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
            send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
            send_byte(a0, 1'b0, 1'b0, '0);
            send_byte(a1, 1'b0, 1'b0, '0);
            send_byte(a2, 1'b0, 1'b0, '0);
            sent += 5;
            if (crc_en_shadow) begin
              send_byte(($urandom_range(0, 3) != 0) ?
                        crc_next(crc_next(crc_next(CrcInit, a0), a1), a2) : pick_byte(),
                        1'b0, 1'b0, '0);
              sent++;
            end
          end
          7: begin
            n = $urandom_range(0, 4);
            send_byte(pick_byte(), 1'b1, 1'b0, '0);
            repeat (n) send_byte(pick_byte(), 1'b0, 1'b0, '0);
            sent += n + 1;
          end
          8: begin
            n = $urandom_range(1, 4);
            repeat (n)
              send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0), 1'b0, '0);
            sent += n;
          end
          default: begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte(pick_byte(), 1'b0, 1'b0, '0);
            sent += n;
          end
        endcase
      end
    end

    in_valid_i <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
